// ===== sv/json_nesting_bound_checker_unit_assert.svh =====
// Assertion macros for the JSON nesting bound checker.
// Included by the top level; relies on nothing else.
`ifndef JSON_NESTING_BOUND_CHECKER_UNIT_ASSERT_SVH
`define JSON_NESTING_BOUND_CHECKER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising clock edge out of reset.
`define JNBC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jnbc: implication check failed");
// Next-cycle implication.
`define JNBC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jnbc: next-cycle check failed");
`else
`define JNBC_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define JNBC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== sv/jnbc_pkg.sv =====
// Shared types and constants for the JSON nesting bound checker.
// No dependencies; used by every module of the block.
package jnbc_pkg;

   localparam int ByteW   = 8;
   localparam int DepthW  = 8;
   localparam int LengthW = 16;
   localparam int NestW   = 9;
   localparam int CsrIdxW = 8;
   localparam int CsrDataW = 16;

   localparam logic [DepthW-1:0]  DepthLimitRst  = 8'd16;
   localparam logic [LengthW-1:0] LengthLimitRst = 16'd4096;
   localparam logic [LengthW-1:0] BytesMax       = 16'hFFFF;

   // register indexes
   localparam logic [CsrIdxW-1:0] RegDepthLimit  = 8'd0;
   localparam logic [CsrIdxW-1:0] RegLengthLimit = 8'd1;

   // characters of interest
   localparam logic [ByteW-1:0] ChNul       = 8'h00;
   localparam logic [ByteW-1:0] ChBackslash = 8'h5C;
   localparam logic [ByteW-1:0] ChQuote     = 8'h22;
   localparam logic [ByteW-1:0] ChLBrace    = 8'h7B;
   localparam logic [ByteW-1:0] ChLBracket  = 8'h5B;
   localparam logic [ByteW-1:0] ChRBrace    = 8'h7D;
   localparam logic [ByteW-1:0] ChRBracket  = 8'h5D;

   typedef struct packed {
      logic [DepthW-1:0]  depth_limit;
      logic [LengthW-1:0] length_limit;
   } cfg_type;

   // verdict handed from the tracker to the result register
   typedef struct packed {
      logic load;
      logic bounded_ok;
   } verdict_type;

endpackage

// ===== sv/jnbc_in_stage.sv =====
// Input register of the JSON nesting bound checker: holds one byte beat.
// Depends on jnbc_pkg.
module jnbc_in_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [jnbc_pkg::ByteW-1:0]   in_byte,
   input  logic                         advance,
   output logic                         held_valid,
   output logic [jnbc_pkg::ByteW-1:0]   held_byte
);

   logic                       valid_ff, valid_in;
   logic [jnbc_pkg::ByteW-1:0] byte_ff;

   assign in_ready   = !valid_ff || advance;
   assign valid_in   = (in_valid && in_ready) || (valid_ff && !advance);
   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         byte_ff <= in_byte;
      end
   end

endmodule

// ===== sv/jnbc_tracker.sv =====
// Message state of the checker: string, escape, depth, byte count, failure.
// Depends on jnbc_pkg; consumes one byte per advance and emits a verdict on NUL.
module jnbc_tracker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [jnbc_pkg::ByteW-1:0] text_byte,
   input  jnbc_pkg::cfg_type          cfg,
   output jnbc_pkg::verdict_type      verdict
);

   logic                          inside_ff, inside_in;
   logic                          escape_ff, escape_in;
   logic [jnbc_pkg::NestW-1:0]    nest_ff, nest_in;
   logic [jnbc_pkg::LengthW-1:0]  bytes_ff, bytes_in;
   logic                          failed_ff, failed_in;
   logic                          fail_now;
   logic                          is_term;
   logic [jnbc_pkg::NestW:0]      nest_up;

   assign fail_now = failed_ff || (bytes_ff >= cfg.length_limit);
   assign is_term  = (text_byte == jnbc_pkg::ChNul);
   assign nest_up  = {1'b0, nest_ff} + {{jnbc_pkg::NestW{1'b0}}, 1'b1};

   assign verdict.load       = advance && is_term;
   assign verdict.bounded_ok = !fail_now && !inside_ff && (nest_ff == '0);

   always_comb begin
      inside_in = inside_ff;
      escape_in = escape_ff;
      nest_in   = nest_ff;
      bytes_in  = bytes_ff;
      failed_in = failed_ff;
      if (advance) begin
         if (is_term) begin
            inside_in = 1'b0;
            escape_in = 1'b0;
            nest_in   = '0;
            bytes_in  = '0;
            failed_in = 1'b0;
         end else begin
            failed_in = fail_now;
            if (bytes_ff != jnbc_pkg::BytesMax) begin
               bytes_in = bytes_ff + {{(jnbc_pkg::LengthW-1){1'b0}}, 1'b1};
            end
            // hold string and depth tracking once the message has failed
            if (!fail_now) begin
               if (inside_ff) begin
                  if (escape_ff) begin
                     escape_in = 1'b0;
                  end else if (text_byte == jnbc_pkg::ChBackslash) begin
                     escape_in = 1'b1;
                  end else if (text_byte == jnbc_pkg::ChQuote) begin
                     inside_in = 1'b0;
                  end
               end else if (text_byte == jnbc_pkg::ChQuote) begin
                  inside_in = 1'b1;
               end else if (text_byte == jnbc_pkg::ChLBrace ||
                            text_byte == jnbc_pkg::ChLBracket) begin
                  if (nest_up > {2'b00, cfg.depth_limit}) begin
                     failed_in = 1'b1;
                  end else begin
                     nest_in = nest_up[jnbc_pkg::NestW-1:0];
                  end
               end else if (text_byte == jnbc_pkg::ChRBrace ||
                            text_byte == jnbc_pkg::ChRBracket) begin
                  if (nest_ff == '0) begin
                     failed_in = 1'b1;
                  end else begin
                     nest_in = nest_ff - {{(jnbc_pkg::NestW-1){1'b0}}, 1'b1};
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         escape_ff <= 1'b0;
         nest_ff   <= '0;
         bytes_ff  <= '0;
         failed_ff <= 1'b0;
      end else begin
         inside_ff <= inside_in;
         escape_ff <= escape_in;
         nest_ff   <= nest_in;
         bytes_ff  <= bytes_in;
         failed_ff <= failed_in;
      end
   end

endmodule

// ===== sv/jnbc_rsp_reg.sv =====
// Result register of the checker: holds one verdict beat until taken.
// Depends on jnbc_pkg.
module jnbc_rsp_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  jnbc_pkg::verdict_type verdict,
   output logic                  can_load,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic                  out_ok
);

   logic valid_ff, valid_in;
   logic ok_ff;

   assign can_load  = !valid_ff || out_ready;
   assign valid_in  = verdict.load || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_ok    = ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (verdict.load) begin
         ok_ff <= verdict.bounded_ok;
      end
   end

endmodule

// ===== sv/json_nesting_bound_checker_unit.sv =====
// JSON nesting bound checker unit.
// Takes a JSON text one byte beat at a time on the req_ stream; a zero byte
// ends the message and produces one verdict beat on the rsp_ stream
// (bit 0 of rsp_tdata: 1 when balanced, within both limits, outside a string).
// Non-zero bytes produce no beat. Bytes after a failure are still consumed.
// Throughput: one byte per cycle unless a waiting verdict stalls the input.
// After acceptance the terminator passes the input register and the tracker,
// and its verdict is loaded into the result register, which presents the
// verdict beat.
// Configuration: csr_ index 0 is depth_limit (low 8 data bits), index 1 is
// length_limit; other indexes are ignored. csr_ready is always high.
// Reset (synchronous, active high) clears message state and loads
// depth_limit 16, length_limit 4096; no clearing pass is needed.
// When the receiver stalls, the verdict holds in the result register; the
// byte in the input register then waits and req_tready drops until the
// verdict is taken.
// Depends on jnbc_pkg, jnbc_in_stage, jnbc_tracker, jnbc_rsp_reg and the
// assertion header.
`include "json_nesting_bound_checker_unit_assert.svh"

module json_nesting_bound_checker_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] text_byte
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // [0] bounded_ok, [7:1] zero
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [jnbc_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [jnbc_pkg::CsrDataW-1:0] csr_data
);

   jnbc_pkg::cfg_type     cfg_ff, cfg_in;
   jnbc_pkg::verdict_type verdict;
   logic                  held_valid;
   logic [7:0]            held_byte;
   logic                  can_load;
   logic                  advance;
   logic                  bounded_ok;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            jnbc_pkg::RegDepthLimit:  cfg_in.depth_limit  = csr_data[jnbc_pkg::DepthW-1:0];
            jnbc_pkg::RegLengthLimit: cfg_in.length_limit = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_limit  <= jnbc_pkg::DepthLimitRst;
         cfg_ff.length_limit <= jnbc_pkg::LengthLimitRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // advance a byte into the tracker only if a verdict could be stored
   assign advance = held_valid && can_load;

   jnbc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .advance    (advance),
      .held_valid (held_valid),
      .held_byte  (held_byte)
   );

   jnbc_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .text_byte (held_byte),
      .cfg       (cfg_ff),
      .verdict   (verdict)
   );

   jnbc_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .verdict   (verdict),
      .can_load  (can_load),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_ok    (bounded_ok)
   );

   assign rsp_tdata = {7'b0, bounded_ok};

   // a verdict is never loaded over one that is still waiting
   `JNBC_ASSERT_IMPLY(a_no_overwrite, clock, reset, verdict.load, !rsp_tvalid || rsp_tready)
   // a verdict beat appears only after a terminator leaves the input register
   `JNBC_ASSERT_NEXT(a_verdict_src, clock, reset, !rsp_tvalid && !verdict.load, !rsp_tvalid)
   // an empty input register always takes a beat
   `JNBC_ASSERT_IMPLY(a_ready_empty, clock, reset, !held_valid, req_tready)

endmodule
